// ===== hdl/jur_pkg.sv =====
// shared constants and types of the console uart register block
package jur_pkg;

   localparam int JUR_RX_DEPTH = 256;
   localparam int JUR_CHAR_W   = 8;

   // item operation codes
   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_HOST  = 2'd2;

   // configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_ADDRESS    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IRQ_ENABLE_LINE = 2'd1;

   // register layout
   localparam logic [31:0] CTRL_OFFSET     = 32'd4;
   localparam logic [31:0] DATA_VALID_BIT  = 32'h0000_8000;
   localparam logic [5:0]  SHOWN_MAX       = 6'd63;
   localparam logic [15:0] WRITE_SPACE     = 16'd64;
   localparam int          CTRL_RE_BIT     = 0;
   localparam int          CTRL_WE_BIT     = 1;
   localparam int          CTRL_AC_CLR_BIT = 10;

   // one result beat, apart from the character read from the store
   typedef struct packed {
      logic [31:0]           read_data;
      logic                  console_valid;
      logic [JUR_CHAR_W-1:0] console_char;
      logic                  irq_out;
      logic                  input_dropped;
   } rsp_type;

endpackage

// ===== hdl/jtag_uart_registers.sv =====
// console uart register block: data and control/status registers over a receive store
//
// Usage: each req_ beat is a bus read (op 0), a bus write (op 1) or a host
// character (op 2); each one gives exactly one rsp_ beat. The data register sits
// at base_address, the control/status register four above it. Reading the data
// register pops the oldest received character; writing it sends the low byte to
// the console. Host characters land in a receive store of RX_DEPTH entries.
// A result passes the ram read stage and then the output register. One item is taken every
// cycle while rsp_ready stays high: the receive store is a ram with one write
// and one registered read port, and the counters and flags update in the accept
// cycle, so items follow each other back to back. The character popped by a read
// comes out of the ram read register in the cycle after accept.
// When the receiver stalls, one result waits in the output register and one more
// item can sit in the ram read stage; further req_ beats wait for space.
// Reset (synchronous) empties the store, clears enables, pending bits, activity
// and the interrupt line, and sets both configuration registers to zero; no
// clearing pass is needed. csr_ writes are always taken, as csr_ready is tied high.
module jtag_uart_registers #(
   parameter int RX_DEPTH = jur_pkg::JUR_RX_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_op,
   input  logic [31:0]                      req_bus_addr,
   input  logic [31:0]                      req_write_data,
   input  logic [jur_pkg::JUR_CHAR_W-1:0]   req_host_char,
   input  logic                             req_new_string,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [31:0]                      rsp_read_data,
   output logic                             rsp_console_valid,
   output logic [jur_pkg::JUR_CHAR_W-1:0]   rsp_console_char,
   output logic                             rsp_irq_out,
   output logic                             rsp_input_dropped,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [jur_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [31:0]                      csr_write_data
);
   import jur_pkg::*;

   localparam int AW = $clog2(RX_DEPTH);
   localparam int CW = $clog2(RX_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_CNT = CW'(RX_DEPTH);
   localparam logic [CW-1:0] SHOWN_CNT = CW'(SHOWN_MAX);

   // configuration
   logic [31:0] base_ff;
   logic        line_en_ff;

   // block state
   logic [CW-1:0] rx_length_ff, rx_length_in;
   logic [CW-1:0] rx_remaining_ff, rx_remaining_in;
   logic re_ff, re_in, we_ff, we_in, ri_ff, ri_in, wi_ff, wi_in;
   logic ac_ff, ac_in, line_ff, line_in;

   // ram read stage and output register
   logic    p1_valid_ff, p1_use_mem_ff;
   rsp_type p1_ff, p1_in;
   logic    p1_use_mem_in;
   logic    out_valid_ff;
   rsp_type out_ff, out_in;

   logic          req_accept, p1_adv;
   logic [31:0]   ctrl_addr;
   logic [CW-1:0] len_eff, rem_eff, rem_dec;
   logic [5:0]    shown;
   logic          ram_we, ram_re;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [JUR_CHAR_W-1:0] ram_q;

   assign p1_adv     = p1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready  = !p1_valid_ff || p1_adv;
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;
   assign ctrl_addr  = base_ff + CTRL_OFFSET;

   assign len_eff = req_new_string ? '0 : rx_length_ff;
   assign rem_eff = req_new_string ? '0 : rx_remaining_ff;
   assign rem_dec = rx_remaining_ff - CW'(1);
   assign shown   = (rem_dec > SHOWN_CNT) ? SHOWN_MAX : rem_dec[5:0];

   always_comb begin
      rx_length_in    = rx_length_ff;
      rx_remaining_in = rx_remaining_ff;
      re_in   = re_ff;
      we_in   = we_ff;
      ri_in   = ri_ff;
      wi_in   = wi_ff;
      ac_in   = ac_ff;
      line_in = line_ff;
      p1_in   = '0;
      p1_use_mem_in = 1'b0;
      ram_we    = 1'b0;
      ram_re    = 1'b0;
      ram_waddr = len_eff[AW-1:0];
      ram_raddr = AW'(rx_length_ff - rx_remaining_ff);
      case (req_op)
         OP_READ: begin
            if (req_bus_addr == base_ff) begin
               if (rx_remaining_ff != '0) begin
                  rx_remaining_in = rem_dec;
                  p1_in.read_data = DATA_VALID_BIT | {10'd0, shown, 16'd0};
                  p1_use_mem_in   = 1'b1;
                  ram_re          = req_accept;
                  ri_in           = 1'b0;
                  if (line_en_ff) begin
                     line_in = 1'b0;
                  end
               end
            end else if (req_bus_addr == ctrl_addr) begin
               p1_in.read_data = {WRITE_SPACE, 5'd0, ac_ff, wi_ff, ri_ff, 6'd0, we_ff, re_ff};
            end
         end
         OP_WRITE: begin
            if (req_bus_addr == base_ff) begin
               p1_in.console_valid = 1'b1;
               p1_in.console_char  = req_write_data[JUR_CHAR_W-1:0];
               wi_in = 1'b0;
               if (line_en_ff) begin
                  line_in = 1'b0;
               end
            end else if (req_bus_addr == ctrl_addr) begin
               re_in = req_write_data[CTRL_RE_BIT];
               if (req_write_data[CTRL_WE_BIT]) begin
                  we_in = 1'b1;
                  wi_in = 1'b1;
                  ac_in = 1'b1;
                  if (line_en_ff) begin
                     line_in = 1'b1;
                  end
               end else begin
                  we_in = 1'b0;
                  wi_in = 1'b0;
                  if (line_en_ff) begin
                     line_in = 1'b0;
                  end
               end
               if (req_write_data[CTRL_AC_CLR_BIT]) begin
                  ac_in = 1'b0;
               end
            end
         end
         OP_HOST: begin
            rx_length_in    = len_eff;
            rx_remaining_in = rem_eff;
            if (len_eff < DEPTH_CNT) begin
               ram_we          = req_accept;
               rx_length_in    = len_eff + CW'(1);
               rx_remaining_in = rem_eff + CW'(1);
            end else begin
               p1_in.input_dropped = 1'b1;
            end
            if (re_ff) begin
               ri_in = 1'b1;
               if (line_en_ff) begin
                  line_in = 1'b1;
               end
            end
            ac_in = 1'b1;
         end
         default: begin
         end
      endcase
      p1_in.irq_out = line_in;
   end

   jur_ram #(
      .WIDTH(JUR_CHAR_W),
      .DEPTH(RX_DEPTH)
   ) u_rx_store (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(req_host_char),
      .rd_en  (ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff         <= '0;
         line_en_ff      <= 1'b0;
         rx_length_ff    <= '0;
         rx_remaining_ff <= '0;
         re_ff           <= 1'b0;
         we_ff           <= 1'b0;
         ri_ff           <= 1'b0;
         wi_ff           <= 1'b0;
         ac_ff           <= 1'b0;
         line_ff         <= 1'b0;
         p1_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         if (req_accept) begin
            rx_length_in_commit: begin
               rx_length_ff    <= rx_length_in;
               rx_remaining_ff <= rx_remaining_in;
               re_ff           <= re_in;
               we_ff           <= we_in;
               ri_ff           <= ri_in;
               wi_ff           <= wi_in;
               ac_ff           <= ac_in;
               line_ff         <= line_in;
            end
         end
         // configuration must only arrive while idle; the user is bound, the block does not enforce it
         if (csr_valid) begin
            if (csr_index == CSR_BASE_ADDRESS) begin
               base_ff <= csr_write_data;
            end else if (csr_index == CSR_IRQ_ENABLE_LINE) begin
               line_en_ff <= csr_write_data[0];
               if (!csr_write_data[0]) begin
                  line_ff <= 1'b0;
               end
            end
         end
         if (req_accept) begin
            p1_valid_ff <= 1'b1;
         end else if (p1_adv) begin
            p1_valid_ff <= 1'b0;
         end
         if (p1_adv) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // merge the popped character into the read word
   always_comb begin
      out_in = p1_ff;
      if (p1_use_mem_ff) begin
         out_in.read_data = p1_ff.read_data | {{(32-JUR_CHAR_W){1'b0}}, ram_q};
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         p1_ff         <= p1_in;
         p1_use_mem_ff <= p1_use_mem_in;
      end
      if (p1_adv) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_read_data     = out_ff.read_data;
   assign rsp_console_valid = out_ff.console_valid;
   assign rsp_console_char  = out_ff.console_char;
   assign rsp_irq_out       = out_ff.irq_out;
   assign rsp_input_dropped = out_ff.input_dropped;

   // counters stay consistent
   assert property (@(posedge clock) disable iff (reset) rx_remaining_ff <= rx_length_ff)
      else $error("remaining count exceeds stored length");
   assert property (@(posedge clock) disable iff (reset) rx_length_ff <= DEPTH_CNT)
      else $error("stored length exceeds store depth");
   // the line only rises while it is enabled
   assert property (@(posedge clock) disable iff (reset) line_ff |-> line_en_ff)
      else $error("interrupt line high while disabled");
   // the ram read register must hold while its stage is stalled
   assert property (@(posedge clock) disable iff (reset)
                    (p1_valid_ff && !p1_adv) |-> !ram_re)
      else $error("ram read issued over a stalled read stage");

endmodule

// ===== hdl/jur_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
module jur_ram #(
   parameter int WIDTH = jur_pkg::JUR_CHAR_W,
   parameter int DEPTH = jur_pkg::JUR_RX_DEPTH
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== dv/tb_top.sv =====
// testbench for the console uart register block: random and directed beats against a scoreboard
module tb_top;
   import jur_pkg::*;

   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam int         STAT_RI_BIT = 8;
   localparam int         STAT_WI_BIT = 9;
   localparam int         STAT_AC_BIT = 10;

   typedef struct packed {
      logic [1:0]            op;
      logic [31:0]           addr;
      logic [31:0]           wdata;
      logic [JUR_CHAR_W-1:0] hchar;
      logic                  new_str;
   } uart_req_t;

   class uart_reg_scoreboard;
      logic [JUR_CHAR_W-1:0] rx_chars [JUR_RX_DEPTH];
      int unsigned           rx_count;
      int unsigned           rx_left;
      bit                    re, we, ri, wi, active, line, line_en;
      logic [31:0]           base_addr;
      rsp_type               expected_replies [$];
      int unsigned           errors;

      function new();
         rx_count  = 0;
         rx_left   = 0;
         re        = 0;
         we        = 0;
         ri        = 0;
         wi        = 0;
         active    = 0;
         line      = 0;
         line_en   = 0;
         base_addr = '0;
         errors    = 0;
      endfunction

      function void drive_line(bit level);
         if (line_en)
            line = level;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] idx, logic [31:0] data);
         if (idx == CSR_BASE_ADDRESS) begin
            base_addr = data;
         end else if (idx == CSR_IRQ_ENABLE_LINE) begin
            line_en = data[0];
            if (!line_en)
               line = 0;
         end
      endfunction

      function rsp_type access_registers(uart_req_t r);
         rsp_type     rsp;
         logic [31:0] ctrl_addr;
         logic [31:0] shown;
         rsp = '0;
         ctrl_addr = base_addr + CTRL_OFFSET;
         case (r.op)
            OP_READ: begin
               if (r.addr == base_addr) begin
                  if (rx_left != 0) begin
                     rx_left--;
                     shown = (rx_left > SHOWN_MAX) ? 32'(SHOWN_MAX) : rx_left;
                     rsp.read_data = 32'(rx_chars[rx_count - rx_left - 1])
                                     | DATA_VALID_BIT | (shown << 16);
                     ri = 0;
                     drive_line(0);
                  end
               end else if (r.addr == ctrl_addr) begin
                  rsp.read_data = (32'(WRITE_SPACE) << 16) | (32'(active) << STAT_AC_BIT)
                                  | (32'(wi) << STAT_WI_BIT) | (32'(ri) << STAT_RI_BIT)
                                  | (32'(we) << CTRL_WE_BIT) | (32'(re) << CTRL_RE_BIT);
               end
            end
            OP_WRITE: begin
               if (r.addr == base_addr) begin
                  rsp.console_valid = 1'b1;
                  rsp.console_char  = r.wdata[JUR_CHAR_W-1:0];
                  wi = 0;
                  drive_line(0);
               end else if (r.addr == ctrl_addr) begin
                  re = r.wdata[CTRL_RE_BIT];
                  if (r.wdata[CTRL_WE_BIT]) begin
                     we = 1;
                     wi = 1;
                     drive_line(1);
                     active = 1;
                  end else begin
                     we = 0;
                     wi = 0;
                     drive_line(0);
                  end
                  if (r.wdata[CTRL_AC_CLR_BIT])
                     active = 0;
               end
            end
            OP_HOST: begin
               // a new string throws away whatever is still unread
               if (r.new_str) begin
                  rx_count = 0;
                  rx_left  = 0;
               end
               if (rx_count < JUR_RX_DEPTH) begin
                  rx_chars[rx_count] = r.hchar;
                  rx_count++;
                  rx_left++;
               end else begin
                  rsp.input_dropped = 1'b1;
               end
               if (re) begin
                  ri = 1;
                  drive_line(1);
               end
               active = 1;
            end
            default: ;
         endcase
         rsp.irq_out = line;
         return rsp;
      endfunction

      function void note_request(uart_req_t r);
         expected_replies.push_back(access_registers(r));
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_replies.size() == 0) begin
            errors++;
            $display("%0t: result beat with nothing expected, actual %h", $time, got);
            return;
         end
         want = expected_replies.pop_front();
         compare_field("read_data", want.read_data, got.read_data);
         compare_field("console_valid", 32'(want.console_valid), 32'(got.console_valid));
         compare_field("console_char", 32'(want.console_char), 32'(got.console_char));
         compare_field("irq_out", 32'(want.irq_out), 32'(got.irq_out));
         compare_field("input_dropped", 32'(want.input_dropped), 32'(got.input_dropped));
      endfunction

      function int pending();
         return expected_replies.size();
      endfunction
   endclass

   logic                   clock;
   logic                   reset          = 1'b1;
   logic                   req_valid      = 1'b0;
   logic                   req_ready;
   logic [1:0]             req_op         = '0;
   logic [31:0]            req_bus_addr   = '0;
   logic [31:0]            req_write_data = '0;
   logic [JUR_CHAR_W-1:0]  req_host_char  = '0;
   logic                   req_new_string = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready      = 1'b0;
   logic [31:0]            rsp_read_data;
   logic                   rsp_console_valid;
   logic [JUR_CHAR_W-1:0]  rsp_console_char;
   logic                   rsp_irq_out;
   logic                   rsp_input_dropped;
   logic                   csr_valid      = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index      = '0;
   logic [31:0]            csr_write_data = '0;

   uart_reg_scoreboard sb;
   int                 send_idle_pct = 0;
   int                 stall_pct     = 0;
   int                 stall_hold    = 0;
   logic [31:0]        base_cfg      = '0;

   jtag_uart_registers u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_bus_addr     (req_bus_addr),
      .req_write_data   (req_write_data),
      .req_host_char    (req_host_char),
      .req_new_string   (req_new_string),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_read_data    (rsp_read_data),
      .rsp_console_valid(rsp_console_valid),
      .rsp_console_char (rsp_console_char),
      .rsp_irq_out      (rsp_irq_out),
      .rsp_input_dropped(rsp_input_dropped),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(20 * 600000);
      $display("jtag_uart_registers verification failed");
      $finish;
   end

   // receiver: random stalls, or a long hold-off counted down here
   always @(posedge clock) begin
      if (stall_hold != 0) begin
         rsp_ready  <= 1'b0;
         stall_hold <= stall_hold - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         sb.note_request({req_op, req_bus_addr, req_write_data, req_host_char, req_new_string});
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response({rsp_read_data, rsp_console_valid, rsp_console_char,
                            rsp_irq_out, rsp_input_dropped});
   end

   always @(posedge clock) begin
      if (!reset && csr_valid && csr_ready)
         sb.write_register(csr_index, csr_write_data);
   end

   function automatic uart_req_t bus_item(logic [1:0] op, logic [31:0] addr,
                                          logic [31:0] data);
      uart_req_t it;
      it.op      = op;
      it.addr    = addr;
      it.wdata   = data;
      it.hchar   = JUR_CHAR_W'($urandom);
      it.new_str = 1'($urandom);
      return it;
   endfunction

   function automatic uart_req_t host_item(logic [JUR_CHAR_W-1:0] ch, logic ns);
      uart_req_t it;
      it.op      = OP_HOST;
      it.addr    = $urandom;
      it.wdata   = $urandom;
      it.hchar   = ch;
      it.new_str = ns;
      return it;
   endfunction

   task automatic send_item(uart_req_t it);
      int gap;
      req_valid      <= 1'b1;
      req_op         <= it.op;
      req_bus_addr   <= it.addr;
      req_write_data <= it.wdata;
      req_host_char  <= it.hchar;
      req_new_string <= it.new_str;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      gap = 0;
      while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [31:0] data);
      csr_valid      <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic configure(logic [31:0] base, logic line_on);
      write_csr(CSR_BASE_ADDRESS, base);
      write_csr(CSR_IRQ_ENABLE_LINE, {31'($urandom), line_on});
      base_cfg = base;
   endtask

   task automatic run_directed();
      send_item(bus_item(OP_READ, base_cfg, '0));             // empty pop
      send_item(bus_item(OP_READ, base_cfg + CTRL_OFFSET, '0));
      send_item(bus_item(OP_WRITE, base_cfg + CTRL_OFFSET, 32'h0000_0003));
      send_item(host_item(8'hFF, 1'b1));
      send_item(host_item(8'h00, 1'b0));
      send_item(bus_item(OP_READ, base_cfg + CTRL_OFFSET, '0));
      send_item(bus_item(OP_READ, base_cfg, '0));             // line drops with wi still set
      send_item(bus_item(OP_WRITE, base_cfg, 32'hFFFF_FFA5));
      send_item(bus_item(OP_WRITE, base_cfg + CTRL_OFFSET, 32'h0000_0400));
      send_item(bus_item(OP_WRITE, base_cfg + CTRL_OFFSET, 32'hFFFF_FFFF));
      send_item(bus_item(OP_READ, base_cfg + CTRL_OFFSET, '0));
      send_item('{OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1});
      send_item(bus_item(OP_READ, 32'hFFFF_FFFF, '0));
      send_item(bus_item(OP_WRITE, 32'h0000_0008, 32'hFFFF_FFFF));
      send_item(host_item(8'h5A, 1'b1));
      send_item(bus_item(OP_READ, base_cfg, '0));
      send_item(bus_item(OP_READ, base_cfg, '0));
      send_item(bus_item(OP_READ, base_cfg + CTRL_OFFSET, '0));
   endtask

   task automatic run_traffic(int budget);
      int          done_items;
      int          kind;
      int          len;
      logic [31:0] ctrl;
      logic [31:0] word;
      logic [31:0] addr;
      done_items = 0;
      while (done_items < budget) begin
         kind = $urandom_range(99);
         ctrl = base_cfg + CTRL_OFFSET;
         if (kind < 28) begin
            // host string, now and then long enough to pass the count cap
            len = ($urandom_range(9) == 0) ? $urandom_range(64, 120) : $urandom_range(1, 16);
            for (int i = 0; i < len; i++)
               send_item(host_item(JUR_CHAR_W'($urandom),
                                   (i == 0) ? ($urandom_range(2) == 0)
                                            : ($urandom_range(29) == 0)));
            done_items += len;
         end else if (kind < 55) begin
            len = $urandom_range(1, 24);
            for (int i = 0; i < len; i++)
               send_item(bus_item(OP_READ, base_cfg, $urandom));
            done_items += len;
         end else if (kind < 66) begin
            word = $urandom;
            if ($urandom_range(2) != 0)
               word[CTRL_AC_CLR_BIT] = 1'b0;
            send_item(bus_item(OP_WRITE, ctrl, word));
            send_item(bus_item(OP_READ, ctrl, $urandom));
            done_items += 2;
         end else if (kind < 78) begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
               send_item(bus_item(OP_WRITE, base_cfg, $urandom));
            done_items += len;
         end else if (kind < 84) begin
            send_item(bus_item(OP_READ, ctrl, $urandom));
            done_items++;
         end else if (kind < 86) begin
            // overfill the store so characters get dropped
            len = JUR_RX_DEPTH + $urandom_range(1, 24);
            for (int i = 0; i < len; i++)
               send_item(host_item(JUR_CHAR_W'($urandom), i == 0));
            done_items += len;
         end else if (kind < 87) begin
            wait_drained();
         end else begin
            len = $urandom_range(1, 4);
            for (int i = 0; i < len; i++) begin
               case ($urandom_range(3))
                  0:       addr = $urandom;
                  1:       addr = base_cfg + 32'($urandom_range(1, 3));
                  2:       addr = base_cfg - CTRL_OFFSET;
                  default: addr = ctrl + 32'($urandom_range(1, 3));
               endcase
               send_item(bus_item(2'($urandom_range(3)), addr, $urandom));
            end
            done_items += len;
         end
      end
   endtask

   initial begin
      logic [31:0] bases [8];
      bit          lines [8];
      int          spin;
      sb = new();
      bases = '{32'h0000_0000, 32'hFFFF_FFFC, 32'hFFFF_FFFF, 32'h0,
                32'h8000_0000, 32'h0, 32'hFFFF_FFFC, 32'h0};
      bases[3] = $urandom;
      bases[5] = $urandom & 32'hFFFF_FFFC;
      bases[7] = $urandom;
      lines = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      configure(32'h0, 1'b1);
      run_directed();
      for (int p = 0; p < 8; p++) begin
         wait_drained();
         repeat (4) @(posedge clock);
         configure(bases[p], lines[p]);
         case (p % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct <= 0;
            end
            1: begin
               send_idle_pct = 77;
               stall_pct <= 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct <= 77;
            end
            default: begin
               send_idle_pct = 12;
               stall_pct <= 12;
            end
         endcase
         if (p == 4) begin
            // receiver holds off while beats keep coming, so the input backs up
            stall_hold <= 250;
            for (int i = 0; i < 40; i++)
               send_item(($urandom_range(1) == 0)
                         ? host_item(JUR_CHAR_W'($urandom), 1'b0)
                         : bus_item(OP_READ, base_cfg + CTRL_OFFSET, $urandom));
         end
         run_traffic(200);
      end
      req_valid <= 1'b0;
      spin = 0;
      while (sb.pending() != 0 && spin < 5000) begin
         @(posedge clock);
         spin++;
      end
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("jtag_uart_registers verification clean");
      end else begin
         if (sb.pending() != 0)
            $display("%0t: %0d expected results never arrived", $time, sb.pending());
         $display("jtag_uart_registers verification failed");
      end
      $finish;
   end

endmodule
